[hdl/bbd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bbd_pkg
// Shared types, constants and interpolation functions of the bilinear
// RGGB Bayer demosaic core.
// ----------------------------------------------------------------------------
package bbd_pkg;

	localparam int PIX_W         = 16;
	localparam int COL_W         = 12;
	localparam int ROW_W         = 16;
	localparam int WID_W         = 13;
	localparam int HGT_W         = 16;
	localparam int CFG_IDX_W     = 1;
	localparam int CFG_DATA_W    = 16;
	localparam int MAX_WIDTH_DEF = 4096;
	localparam int JOB_DEPTH     = 4;
	localparam int JOB_PTR_W     = $clog2(JOB_DEPTH);
	localparam int JOB_CNT_W     = $clog2(JOB_DEPTH + 1);

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

	localparam logic [WID_W-1:0] WIDTH_RESET  = 13'd4096;
	localparam logic [HGT_W-1:0] HEIGHT_RESET = 16'd1024;

	// window row selects
	localparam logic [1:0] ROW_OLDER = 2'd0;
	localparam logic [1:0] ROW_NEWER = 2'd1;
	localparam logic [1:0] ROW_INCOMING = 2'd2;

	typedef logic [PIX_W-1:0] pix_t;
	// one window column: [0] older row, [1] newer row, [2] incoming row
	typedef pix_t [2:0] pcol_t;
	// window: [0] left, [1] center, [2] right column
	typedef pcol_t [2:0] win_t;

	typedef struct packed {
		win_t             win;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic             has_a;   // result(s) for column col-1
		logic             has_b;   // result(s) for column col (row end)
		logic             last;    // bottom row follows each result
		logic             top;     // top row mirrors row 1
	} job_t;

	typedef struct packed {
		pix_t red;
		pix_t green;
		pix_t blue;
	} rgb_t;

	function automatic pix_t avg2(input pix_t a, input pix_t b);
		logic [PIX_W:0] sum;
		sum = {1'b0, a} + {1'b0, b} + {{PIX_W{1'b0}}, 1'b1};
		return sum[PIX_W:1];
	endfunction

	// Interpolates the center column of w using rows t, m, b.
	function automatic rgb_t demosaic(input win_t w, input logic [1:0] t,
		input logic [1:0] m, input logic [1:0] b, input logic y0, input logic x0);
		pix_t tl, tm, tr, ml, mm, mr, bl, bm, br;
		pix_t horiz, vert, diag;
		rgb_t o;
		tl = w[0][t]; tm = w[1][t]; tr = w[2][t];
		ml = w[0][m]; mm = w[1][m]; mr = w[2][m];
		bl = w[0][b]; bm = w[1][b]; br = w[2][b];
		horiz = avg2(ml, mr);
		vert  = avg2(tm, bm);
		diag  = avg2(avg2(tl, tr), avg2(bl, br));
		unique case ({y0, x0})
			2'b00: begin
				o.red = mm; o.green = horiz; o.blue = diag;
			end
			2'b01: begin
				o.red = horiz; o.green = mm; o.blue = vert;
			end
			2'b10: begin
				o.red = vert; o.green = mm; o.blue = horiz;
			end
			default: begin
				o.red = diag; o.green = avg2(vert, horiz); o.blue = mm;
			end
		endcase
		return o;
	endfunction

endpackage
`default_nettype wire

[hdl/bayer_bilinear_demosaic_core.sv]
`default_nettype none
// Path: a result passes stage-1 registers, job queue and output register after the
// last sample of its 3x3 window; images run one row and one column behind the input.
// Throughput: 1 pixel per cycle while the job queue has room, set by the line
// store's single read-modify-write per column; the bottom row gives two results per
// sample and a row end gives one extra result, drained through a 4-entry job queue.
// Reset: counters and window clear, width 4096, height 1024; line store not cleared.
// ----------------------------------------------------------------------------
// bayer_bilinear_demosaic_core
// Streams raw RGGB samples through a two-row line store and a 3x3 window and
// emits a bilinear red/green/blue triple per pixel.
// ----------------------------------------------------------------------------
module bayer_bilinear_demosaic_core
	import bbd_pkg::*;
#(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [PIX_W-1:0]      raw_pixel,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [PIX_W-1:0]           red,
	output logic [PIX_W-1:0]           green,
	output logic [PIX_W-1:0]           blue,
	output logic [COL_W-1:0]           out_column,
	output logic [ROW_W-1:0]           out_row,
	output logic                       last_of_run
);

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);

	// ---------------- configuration ----------------
	logic [WID_W-1:0] image_width_q;
	logic [HGT_W-1:0] image_height_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= WIDTH_RESET;
			image_height_q <= HEIGHT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  image_width_q  <= cfg_data[WID_W-1:0];
				REG_IMAGE_HEIGHT: image_height_q <= cfg_data[HGT_W-1:0];
				default: ;
			endcase
		end
	end

	logic [WW-1:0]    w_eff;
	logic [HGT_W-1:0] h_eff;

	always_comb begin
		if (image_width_q == '0)
			w_eff = WW'(1);
		else if (32'(image_width_q) > MAX_WIDTH)
			w_eff = WW'(MAX_WIDTH);
		else
			w_eff = WW'(image_width_q);
		h_eff = (image_height_q < HGT_W'(2)) ? HGT_W'(2) : image_height_q;
	end

	// ---------------- stage 0: counters, line store read ----------------
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic             accept;
	logic             endrow;
	logic             last;
	logic             memop;
	logic [AW-1:0]    addr;

	logic [JOB_CNT_W-1:0] job_cnt_q;
	logic                 s1_valid;

	assign in_ready = ({1'b0, job_cnt_q} + (JOB_CNT_W+1)'(s1_valid))
		< (JOB_CNT_W+1)'(JOB_DEPTH);
	assign accept = in_valid && in_ready;
	assign endrow = (32'(col_q) + 32'd1) >= 32'(w_eff);
	assign last   = ({1'b0, row_q} + (ROW_W+1)'(1)) >= {1'b0, h_eff};
	assign memop  = 32'(col_q) < MAX_WIDTH;
	assign addr   = AW'(col_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			col_q <= endrow ? '0 : col_q + COL_W'(1);
			if (endrow)
				row_q <= last ? '0 : row_q + ROW_W'(1);
		end
	end

	// ---------------- stage 1 registers ----------------
	logic [COL_W-1:0]   col_s1;
	logic [ROW_W-1:0]   row_s1;
	logic               endrow_s1;
	logic               last_s1;
	logic               memop_s1;
	logic [AW-1:0]      addr_s1;
	pix_t               px_s1;
	logic               fwd_s1;
	logic [2*PIX_W-1:0] fwd_data_s1;
	logic [2*PIX_W-1:0] rd_s1;
	pix_t               a_s1, b_s1;

	// line store: {older row, newer row} per column
	logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];

	always_ff @(posedge clk) begin
		if (s1_valid && memop_s1)
			line_mem[addr_s1] <= {b_s1, px_s1};
		if (accept && memop)
			rd_s1 <= line_mem[addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_valid <= 1'b0;
		else
			s1_valid <= accept;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			col_s1      <= col_q;
			row_s1      <= row_q;
			endrow_s1   <= endrow;
			last_s1     <= last;
			memop_s1    <= memop;
			addr_s1     <= addr;
			px_s1       <= raw_pixel;
			// write in flight to the same column: take its data instead
			fwd_s1      <= s1_valid && memop_s1 && memop && (addr_s1 == addr);
			fwd_data_s1 <= {b_s1, px_s1};
		end
	end

	always_comb begin
		if (!memop_s1) begin
			a_s1 = '0;
			b_s1 = '0;
		end else if (fwd_s1) begin
			a_s1 = fwd_data_s1[2*PIX_W-1:PIX_W];
			b_s1 = fwd_data_s1[PIX_W-1:0];
		end else begin
			a_s1 = rd_s1[2*PIX_W-1:PIX_W];
			b_s1 = rd_s1[PIX_W-1:0];
		end
	end

	// ---------------- stage 1: window update, job push ----------------
	win_t window_q;
	win_t win_base;
	win_t win1;
	win_t win2;
	job_t job_in;
	logic push;

	always_comb begin
		win_base = (col_s1 == '0) ? '0 : window_q;
		win1[0] = win_base[1];
		win1[1] = win_base[2];
		win1[2][ROW_OLDER]    = a_s1;
		win1[2][ROW_NEWER]    = b_s1;
		win1[2][ROW_INCOMING] = px_s1;
		win2[0] = win1[1];
		win2[1] = win1[2];
		win2[2] = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			window_q <= '0;
		else if (s1_valid)
			window_q <= endrow_s1 ? win2 : win1;
	end

	always_comb begin
		job_in.win   = win1;
		job_in.col   = col_s1;
		job_in.row   = row_s1;
		job_in.has_a = (col_s1 != '0) && (row_s1 != '0);
		job_in.has_b = endrow_s1 && (row_s1 != '0);
		job_in.last  = last_s1;
		job_in.top   = (row_s1 == ROW_W'(1));
	end

	assign push = s1_valid && (job_in.has_a || job_in.has_b);

	// ---------------- job queue ----------------
	job_t                 job_mem [JOB_DEPTH];
	logic [JOB_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic                 pop;
	job_t                 head;

	assign head = job_mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			job_mem[wr_ptr_q] <= job_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q  <= '0;
			rd_ptr_q  <= '0;
			job_cnt_q <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + JOB_PTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + JOB_PTR_W'(1);
			unique case ({push, pop})
				2'b10:   job_cnt_q <= job_cnt_q + JOB_CNT_W'(1);
				2'b01:   job_cnt_q <= job_cnt_q - JOB_CNT_W'(1);
				default: job_cnt_q <= job_cnt_q;
			endcase
		end
	end

	// ---------------- result sequencer and output register ----------------
	logic             started_q, sel_b_q, bot_q;
	logic             cur_b, cur_bot;
	logic             nxt_b, nxt_bot, done;
	logic             load;
	win_t             win_sel;
	logic [1:0]       rt, rm, rb;
	logic [ROW_W-1:0] y;
	logic [COL_W-1:0] x;
	rgb_t             rgb;
	logic             out_valid_q;

	assign load    = (job_cnt_q != '0) && (!out_valid_q || out_ready);
	assign cur_b   = started_q ? sel_b_q : !head.has_a;
	assign cur_bot = started_q && bot_q;

	always_comb begin
		nxt_b   = cur_b;
		nxt_bot = cur_bot;
		done    = 1'b0;
		if (!cur_bot && head.last) begin
			nxt_bot = 1'b1;
		end else if (!cur_b && head.has_b) begin
			nxt_b   = 1'b1;
			nxt_bot = 1'b0;
		end else begin
			done = 1'b1;
		end
	end

	assign pop = load && done;

	always_comb begin
		if (cur_b) begin
			win_sel[0] = head.win[1];
			win_sel[1] = head.win[2];
			win_sel[2] = '0;
		end else begin
			win_sel = head.win;
		end
		if (cur_bot) begin
			rt = ROW_NEWER; rm = ROW_INCOMING; rb = ROW_NEWER;
			y  = head.row;
		end else begin
			rt = head.top ? ROW_INCOMING : ROW_OLDER;
			rm = ROW_NEWER;
			rb = ROW_INCOMING;
			y  = head.row - ROW_W'(1);
		end
		x   = cur_b ? head.col : head.col - COL_W'(1);
		rgb = demosaic(win_sel, rt, rm, rb, y[0], x[0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q   <= 1'b0;
			sel_b_q     <= 1'b0;
			bot_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				started_q <= !done;
				sel_b_q   <= nxt_b;
				bot_q     <= nxt_bot;
			end
			if (load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			red         <= rgb.red;
			green       <= rgb.green;
			blue        <= rgb.blue;
			out_column  <= x;
			out_row     <= y;
			last_of_run <= done;
		end
	end

	assign out_valid = out_valid_q;

	// ---------------- assertions ----------------
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		job_cnt_q <= JOB_CNT_W'(JOB_DEPTH))
		else $error("job queue count beyond depth");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (job_cnt_q < JOB_CNT_W'(JOB_DEPTH)) || pop)
		else $error("job pushed into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> job_cnt_q != '0)
		else $error("job popped from an empty queue");

	a_row_end_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid && endrow_s1 |-> col_q == '0)
		else $error("column counter did not wrap at row end");

	a_bottom_only_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		load && cur_bot |-> head.last)
		else $error("bottom-row result on a job that is not on the last row");

endmodule
`default_nettype wire
